[rtl/kpled_pkg.sv]
package kpled_pkg;

  // Event codes carried in the mode field
  typedef enum logic [2:0] {
    ModeTick    = 3'd0,
    ModeDigit   = 3'd1,
    ModeSegment = 3'd2,
    ModeKeyRead = 3'd3,
    ModeStatus  = 3'd4
  } mode_e;

  localparam int unsigned NumRows     = 4;
  localparam int unsigned NumCols     = 5;
  localparam int unsigned NumOutDigit = 6;
  localparam int unsigned MaxDigits   = 8;

  localparam logic [7:0] TimeoutReset = 8'd128;
  localparam logic [7:0] KeyReadBase  = 8'hC0;
  localparam logic [7:0] NoShiftBit   = 8'h20;
  localparam logic [7:0] KeyUpBit     = 8'h40;
  localparam logic [7:0] TapeBit      = 8'h80;

  typedef logic [NumCols-1:0] row_keys_t;

  // Key encoder state
  typedef struct packed {
    logic [4:0] key_code;
    logic [1:0] scan_row;
    logic       key_down;
    logic       irq_pending;
  } key_state_t;

  // Reorder the segment byte to the display wiring
  function automatic logic [7:0] permute_segments(logic [7:0] d);
    return {d[4], d[2], d[1], d[6], d[7], d[5], d[3], d[0]};
  endfunction

  // Row in the low bits, lowest pressed column above it
  function automatic logic [4:0] encode_key(row_keys_t cols, logic [1:0] row);
    logic [2:0] col;
    col = 3'd0;
    priority if (cols[0]) col = 3'd0;
    else if (cols[1])     col = 3'd1;
    else if (cols[2])     col = 3'd2;
    else if (cols[3])     col = 3'd3;
    else if (cols[4])     col = 3'd4;
    else                  col = 3'd0;
    return {col, row};
  endfunction

endpackage

[rtl/kpled_key_scan.sv]
module kpled_key_scan (
  input  kpled_pkg::row_keys_t  row0_keys_i,
  input  kpled_pkg::row_keys_t  row1_keys_i,
  input  kpled_pkg::row_keys_t  row2_keys_i,
  input  kpled_pkg::row_keys_t  row3_keys_i,
  input  kpled_pkg::key_state_t state_i,
  output kpled_pkg::key_state_t state_o
);
  import kpled_pkg::*;

  row_keys_t  rows [NumRows];
  row_keys_t  cur_cols;
  row_keys_t  nxt_cols;
  logic [1:0] nxt_row;
  logic       hold;

  assign rows[0] = row0_keys_i;
  assign rows[1] = row1_keys_i;
  assign rows[2] = row2_keys_i;
  assign rows[3] = row3_keys_i;

  // Hold the row while the same key stays down
  assign cur_cols = rows[state_i.scan_row];
  assign hold     = (cur_cols != '0) &&
                    (encode_key(cur_cols, state_i.scan_row) == state_i.key_code);
  assign nxt_row  = state_i.scan_row + 2'd1;
  assign nxt_cols = rows[nxt_row];

  // Advance to the next row and encode any pressed key there
  always_comb begin
    state_o = state_i;
    if (!hold) begin
      state_o.scan_row = nxt_row;
      if (nxt_cols != '0) begin
        state_o.key_code    = encode_key(nxt_cols, nxt_row);
        state_o.irq_pending = 1'b1;
        state_o.key_down    = 1'b1;
      end else begin
        state_o.key_down = 1'b0;
      end
    end
  end

endmodule

[rtl/keypad_scan_and_led_refresh_core.sv]
// Keypad scan and LED refresh core.
// Each transaction goes through the input register, then the result register.
// Throughput: one event per cycle unless out_ready_i stalls; each is done in a single pass.
// Reset: control and block state cleared, blank timeout 128, no transaction held.
module keypad_scan_and_led_refresh_core #(
  parameter int unsigned NUM_DIGITS = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] mode_i,
  input  logic [7:0] write_data_i,
  input  logic [4:0] row0_keys_i,
  input  logic [4:0] row1_keys_i,
  input  logic [4:0] row2_keys_i,
  input  logic [4:0] row3_keys_i,
  input  logic       shift_held_i,
  input  logic       tape_in_high_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o,
  output logic [7:0] digit0_segments_o,
  output logic [7:0] digit1_segments_o,
  output logic [7:0] digit2_segments_o,
  output logic [7:0] digit3_segments_o,
  output logic [7:0] digit4_segments_o,
  output logic [7:0] digit5_segments_o,
  output logic       speaker_level_o,
  output logic       key_interrupt_o
);
  import kpled_pkg::*;

  // Control and configuration state
  logic       in_vld_q;
  logic       res_vld_q;
  logic [7:0] timeout_q;

  // Input register
  logic [2:0] mode_q;
  logic [7:0] wdata_q;
  row_keys_t  row0_q, row1_q, row2_q, row3_q;
  logic       shift_q;
  logic       tape_q;

  // Block state
  key_state_t key_q, key_d, key_tick;
  logic [7:0] seg_latch_q, seg_latch_d;
  logic [5:0] dig_sel_q, dig_sel_d;
  logic       spk_q, spk_d;
  logic [7:0] age_q   [NUM_DIGITS];
  logic [7:0] age_d   [NUM_DIGITS];
  logic [7:0] shown_q [NUM_DIGITS];
  logic [7:0] shown_d [NUM_DIGITS];

  // Result register
  logic [7:0] rd_q, rd_d;
  logic [7:0] res_seg_q [NumOutDigit];
  logic [7:0] res_seg_d [NumOutDigit];
  logic       res_spk_q;
  logic       res_irq_q;

  logic       advance;
  logic       accept;
  logic       is_tick;
  logic [MaxDigits-1:0] sel_wide;

  assign advance    = in_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign accept     = in_valid_i && in_ready_o;
  assign is_tick    = (mode_q == ModeTick);
  assign sel_wide   = {{(MaxDigits-6){1'b0}}, dig_sel_q};

  kpled_key_scan u_key_scan (
    .row0_keys_i (row0_q),
    .row1_keys_i (row1_q),
    .row2_keys_i (row2_q),
    .row3_keys_i (row3_q),
    .state_i     (key_q),
    .state_o     (key_tick)
  );

  // Decode the event held in the input register
  always_comb begin
    key_d       = key_q;
    seg_latch_d = seg_latch_q;
    dig_sel_d   = dig_sel_q;
    spk_d       = spk_q;
    rd_d        = 8'h00;
    unique case (mode_e'(mode_q))
      ModeTick:    key_d = key_tick;
      ModeDigit: begin
        spk_d     = wdata_q[7];
        dig_sel_d = wdata_q[5:0];
      end
      ModeSegment: seg_latch_d = permute_segments(wdata_q);
      ModeKeyRead: begin
        key_d.irq_pending = 1'b0;
        rd_d = {3'b000, key_q.key_code} | KeyReadBase | (shift_q ? 8'h00 : NoShiftBit);
      end
      ModeStatus:  rd_d = (key_q.key_down ? 8'h00 : KeyUpBit) | (tape_q ? TapeBit : 8'h00);
      default: ;
    endcase
  end

  // Refresh each digit on a tick: restart selected, blank expired, age the other lit ones
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      age_d[i]   = age_q[i];
      shown_d[i] = shown_q[i];
      if (is_tick) begin
        if (sel_wide[3'(i)]) begin
          age_d[i]   = 8'd1;
          shown_d[i] = seg_latch_q;
        end else if (age_q[i] != 8'd0 && age_q[i] == timeout_q) begin
          age_d[i]   = 8'd0;
          shown_d[i] = 8'd0;
        end else if (age_q[i] != 8'd0) begin
          age_d[i] = age_q[i] + 8'd1;
        end
      end
    end
  end

  // Map digits to the six display outputs, zero where absent
  for (genvar g = 0; g < NumOutDigit; g++) begin : g_out
    if (g < NUM_DIGITS) begin : g_present
      assign res_seg_d[g] = shown_d[g];
    end else begin : g_absent
      assign res_seg_d[g] = 8'd0;
    end
  end

  // Control and block state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      res_vld_q   <= 1'b0;
      timeout_q   <= TimeoutReset;
      key_q       <= '0;
      seg_latch_q <= 8'd0;
      dig_sel_q   <= 6'd0;
      spk_q       <= 1'b0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        age_q[i]   <= 8'd0;
        shown_q[i] <= 8'd0;
      end
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        res_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        res_vld_q <= 1'b0;
      end
      if (advance) begin
        key_q       <= key_d;
        seg_latch_q <= seg_latch_d;
        dig_sel_q   <= dig_sel_d;
        spk_q       <= spk_d;
        for (int i = 0; i < NUM_DIGITS; i++) begin
          age_q[i]   <= age_d[i];
          shown_q[i] <= shown_d[i];
        end
      end
    end
  end

  // Capture the incoming transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      wdata_q <= write_data_i;
      row0_q  <= row0_keys_i;
      row1_q  <= row1_keys_i;
      row2_q  <= row2_keys_i;
      row3_q  <= row3_keys_i;
      shift_q <= shift_held_i;
      tape_q  <= tape_in_high_i;
    end
  end

  // Load the result
  always_ff @(posedge clk_i) begin
    if (advance) begin
      rd_q      <= rd_d;
      res_seg_q <= res_seg_d;
      res_spk_q <= spk_d;
      res_irq_q <= key_d.irq_pending;
    end
  end

  assign out_valid_o       = res_vld_q;
  assign read_data_o       = rd_q;
  assign digit0_segments_o = res_seg_q[0];
  assign digit1_segments_o = res_seg_q[1];
  assign digit2_segments_o = res_seg_q[2];
  assign digit3_segments_o = res_seg_q[3];
  assign digit4_segments_o = res_seg_q[4];
  assign digit5_segments_o = res_seg_q[5];
  assign speaker_level_o   = res_spk_q;
  assign key_interrupt_o   = res_irq_q;

endmodule

[tb/sv/testbench.sv]
module testbench;
  import kpled_pkg::*;

  localparam int unsigned NumDigits   = NumOutDigit;
  localparam logic [2:0]  ModeSpareLo = 3'd5;
  localparam logic [2:0]  ModeSpareHi = 3'd7;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned MaxPrinted   = 40;
  localparam int unsigned LimitCycles  = 400000;
  localparam int unsigned ClockPeriod  = 12;

  // Source bit of the incoming byte for each wired segment bit
  localparam int SegSource [8] = '{0, 3, 5, 7, 6, 1, 2, 4};

  typedef logic [NumRows-1:0][NumCols-1:0] key_matrix_t;

  localparam key_matrix_t NoKeys  = '0;
  localparam key_matrix_t AllKeys = '1;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  wdata;
    key_matrix_t rows;
    logic        shift;
    logic        tape;
  } bus_event_t;

  typedef struct packed {
    logic [7:0]                   read_data;
    logic [NumOutDigit-1:0][7:0]  segments;
    logic                         speaker;
    logic                         irq;
  } panel_view_t;

  // Tracks keypad and display state and the panel views still owed by the block
  class keypad_display_tracker;
    logic [7:0]  blank_timeout;
    logic [4:0]  key_code;
    logic [1:0]  scan_row;
    logic        key_down;
    logic        irq_pending;
    logic [7:0]  segment_latch;
    logic [5:0]  digit_select;
    logic        speaker_bit;
    logic [7:0]  refresh_age [NumDigits];
    logic [7:0]  shown [NumDigits];
    panel_view_t pending_results [$];
    int unsigned errors;

    function new();
      blank_timeout = TimeoutReset;
      key_code      = '0;
      scan_row      = '0;
      key_down      = 1'b0;
      irq_pending   = 1'b0;
      segment_latch = '0;
      digit_select  = '0;
      speaker_bit   = 1'b0;
      errors        = 0;
      foreach (refresh_age[i]) begin
        refresh_age[i] = '0;
        shown[i]       = '0;
      end
    endfunction

    function logic [7:0] wired_segments(logic [7:0] d);
      logic [7:0] r;
      for (int b = 0; b < 8; b++) r[b] = d[SegSource[b]];
      return r;
    endfunction

    // Row number in the low bits, lowest pressed column above
    function logic [4:0] key_number(logic [4:0] cols, logic [1:0] row);
      logic [2:0] col;
      col = '0;
      for (int c = NumCols - 1; c >= 0; c--) if (cols[c]) col = c[2:0];
      return {col, row};
    endfunction

    function void scan_tick(key_matrix_t rows);
      logic [4:0] cols;
      // Refresh selected digits, age and blank the others
      for (int i = 0; i < NumDigits; i++) begin
        if (digit_select[i]) begin
          refresh_age[i] = 8'd1;
          shown[i]       = segment_latch;
        end else if (refresh_age[i] != 0 && refresh_age[i] == blank_timeout) begin
          shown[i]       = '0;
          refresh_age[i] = '0;
        end else if (refresh_age[i] != 0) begin
          refresh_age[i] = refresh_age[i] + 8'd1;
        end
      end
      // Hold the row while the same key stays down
      cols = rows[scan_row];
      if (cols != '0 && key_number(cols, scan_row) == key_code) return;
      scan_row = scan_row + 2'd1;
      cols     = rows[scan_row];
      if (cols != '0) begin
        key_code    = key_number(cols, scan_row);
        irq_pending = 1'b1;
        key_down    = 1'b1;
      end else begin
        key_down = 1'b0;
      end
    endfunction

    function void note_event(bus_event_t ev);
      panel_view_t want;
      want.read_data = '0;
      case (ev.mode)
        ModeTick: scan_tick(ev.rows);
        ModeDigit: begin
          speaker_bit  = ev.wdata[7];
          digit_select = ev.wdata[5:0];
        end
        ModeSegment: segment_latch = wired_segments(ev.wdata);
        ModeKeyRead: begin
          irq_pending    = 1'b0;
          want.read_data = KeyReadBase | {3'b000, key_code} | (ev.shift ? 8'h00 : NoShiftBit);
        end
        ModeStatus: begin
          want.read_data = (key_down ? 8'h00 : KeyUpBit) | (ev.tape ? TapeBit : 8'h00);
        end
        default: ;
      endcase
      for (int i = 0; i < NumDigits; i++) want.segments[i] = shown[i];
      want.speaker = speaker_bit;
      want.irq     = irq_pending;
      pending_results.push_back(want);
    endfunction

    task report(string what, logic [7:0] got, logic [7:0] want);
      if (errors < MaxPrinted)
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
      errors++;
    endtask

    task check_result(panel_view_t got);
      panel_view_t want;
      if (pending_results.size() == 0) begin
        report("result with nothing outstanding, read_data", got.read_data, 8'h00);
        return;
      end
      want = pending_results.pop_front();
      if (got.read_data !== want.read_data) report("read_data", got.read_data, want.read_data);
      for (int i = 0; i < NumDigits; i++)
        if (got.segments[i] !== want.segments[i])
          report($sformatf("digit%0d_segments", i), got.segments[i], want.segments[i]);
      if (got.speaker !== want.speaker) report("speaker_level", got.speaker, want.speaker);
      if (got.irq !== want.irq) report("key_interrupt", got.irq, want.irq);
    endtask
  endclass

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       cfg_we_i       = 1'b0;
  logic [7:0] cfg_wdata_i    = '0;
  logic       in_valid_i     = 1'b0;
  logic       in_ready_o;
  logic [2:0] mode_i         = '0;
  logic [7:0] write_data_i   = '0;
  logic [4:0] row0_keys_i    = '0;
  logic [4:0] row1_keys_i    = '0;
  logic [4:0] row2_keys_i    = '0;
  logic [4:0] row3_keys_i    = '0;
  logic       shift_held_i   = 1'b0;
  logic       tape_in_high_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i    = 1'b0;
  logic [7:0] read_data_o;
  logic [7:0] digit0_segments_o;
  logic [7:0] digit1_segments_o;
  logic [7:0] digit2_segments_o;
  logic [7:0] digit3_segments_o;
  logic [7:0] digit4_segments_o;
  logic [7:0] digit5_segments_o;
  logic       speaker_level_o;
  logic       key_interrupt_o;

  keypad_display_tracker tracker;
  key_matrix_t           held_keys = '0;
  bit                    idling    = 1'b1;

  keypad_scan_and_led_refresh_core #(
    .NUM_DIGITS (NumDigits)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .mode_i            (mode_i),
    .write_data_i      (write_data_i),
    .row0_keys_i       (row0_keys_i),
    .row1_keys_i       (row1_keys_i),
    .row2_keys_i       (row2_keys_i),
    .row3_keys_i       (row3_keys_i),
    .shift_held_i      (shift_held_i),
    .tape_in_high_i    (tape_in_high_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .read_data_o       (read_data_o),
    .digit0_segments_o (digit0_segments_o),
    .digit1_segments_o (digit1_segments_o),
    .digit2_segments_o (digit2_segments_o),
    .digit3_segments_o (digit3_segments_o),
    .digit4_segments_o (digit4_segments_o),
    .digit5_segments_o (digit5_segments_o),
    .speaker_level_o   (speaker_level_o),
    .key_interrupt_o   (key_interrupt_o)
  );

  always begin
    #(ClockPeriod / 2) clk_i = 1'b1;
    #(ClockPeriod / 2) clk_i = 1'b0;
  end

  function automatic bus_event_t make_event(logic [2:0] mode, logic [7:0] wdata,
                                            key_matrix_t rows, logic shift, logic tape);
    bus_event_t ev;
    ev.mode  = mode;
    ev.wdata = wdata;
    ev.rows  = rows;
    ev.shift = shift;
    ev.tape  = tape;
    return ev;
  endfunction

  // Keys mostly stay put across several events so that held keys occur
  function automatic bus_event_t random_event();
    bus_event_t  ev;
    int unsigned pick;
    if ($urandom_range(0, 4) == 0)
      for (int r = 0; r < NumRows; r++)
        held_keys[r] = ($urandom_range(0, 1) != 0) ? 5'd0 : 5'($urandom_range(0, 31));
    pick = $urandom_range(0, 99);
    ev = make_event(ModeTick, 8'($urandom_range(0, 255)), held_keys,
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    if (pick < 40)      ev.mode = ModeTick;
    else if (pick < 55) ev.mode = ModeDigit;
    else if (pick < 70) ev.mode = ModeSegment;
    else if (pick < 82) ev.mode = ModeKeyRead;
    else if (pick < 94) ev.mode = ModeStatus;
    else                ev.mode = 3'($urandom_range(ModeSpareLo, ModeSpareHi));
    return ev;
  endfunction

  // Offer one transaction, starting and ending at a falling edge
  task automatic present(bus_event_t ev);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    mode_i         = ev.mode;
    write_data_i   = ev.wdata;
    row0_keys_i    = ev.rows[0];
    row1_keys_i    = ev.rows[1];
    row2_keys_i    = ev.rows[2];
    row3_keys_i    = ev.rows[3];
    shift_held_i   = ev.shift;
    tape_in_high_i = ev.tape;
    in_valid_i     = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_event(ev);
    @(negedge clk_i);
  endtask

  task automatic tick_run(int unsigned count);
    bus_event_t ev;
    repeat (count) begin
      ev      = random_event();
      ev.mode = ModeTick;
      present(ev);
    end
  endtask

  // Drop valid and hold until every owed result is back
  task automatic drain_and_settle();
    in_valid_i = 1'b0;
    while (tracker.pending_results.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_timeout(logic [7:0] value);
    drain_and_settle();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    tracker.blank_timeout = value;
  endtask

  // Result side: ready with random stall bursts
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        out_ready_i = 1'b0;
        stall_left  = $urandom_range(0, 18);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : watch_results
    panel_view_t seen;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.read_data   = read_data_o;
      seen.segments[0] = digit0_segments_o;
      seen.segments[1] = digit1_segments_o;
      seen.segments[2] = digit2_segments_o;
      seen.segments[3] = digit3_segments_o;
      seen.segments[4] = digit4_segments_o;
      seen.segments[5] = digit5_segments_o;
      seen.speaker     = speaker_level_o;
      seen.irq         = key_interrupt_o;
      tracker.check_result(seen);
    end
  end

  initial begin
    #(LimitCycles * ClockPeriod);
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [7:0] timeout_value;
    tracker = new();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reads from reset, latch extremes, key scan corner cases, spare modes
    present(make_event(ModeStatus,  8'h00, NoKeys, 1'b0, 1'b0));
    present(make_event(ModeStatus,  8'hFF, NoKeys, 1'b0, 1'b1));
    present(make_event(ModeKeyRead, 8'h00, NoKeys, 1'b1, 1'b0));
    present(make_event(ModeKeyRead, 8'h00, NoKeys, 1'b0, 1'b0));
    present(make_event(ModeSegment, 8'hFF, NoKeys, 1'b0, 1'b0));
    present(make_event(ModeDigit,   8'hBF, NoKeys, 1'b0, 1'b0));
    present(make_event(ModeTick,    8'h00, NoKeys, 1'b0, 1'b0));
    present(make_event(ModeSegment, 8'hA5, NoKeys, 1'b0, 1'b0));
    present(make_event(ModeDigit,   8'h7F, NoKeys, 1'b0, 1'b0));
    present(make_event(ModeTick,    8'h00, {5'd0, 5'b10000, 5'd0, 5'd0}, 1'b0, 1'b0));
    present(make_event(ModeStatus,  8'h00, NoKeys, 1'b0, 1'b1));
    present(make_event(ModeTick,    8'h00, {5'd0, 5'b10000, 5'd0, 5'd0}, 1'b0, 1'b0));
    present(make_event(ModeKeyRead, 8'h00, NoKeys, 1'b0, 1'b0));
    present(make_event(ModeTick,    8'h00, {5'b11010, 5'b10110, 5'd0, 5'd0}, 1'b0, 1'b0));
    present(make_event(ModeTick,    8'h00, NoKeys, 1'b0, 1'b0));
    present(make_event(ModeStatus,  8'h00, NoKeys, 1'b1, 1'b0));
    present(make_event(ModeDigit,   8'h80, NoKeys, 1'b0, 1'b0));
    present(make_event(ModeSegment, 8'h00, NoKeys, 1'b0, 1'b0));
    present(make_event(ModeTick,    8'h00, {5'd0, 5'd0, 5'b00001, 5'd0}, 1'b0, 1'b0));
    present(make_event(ModeKeyRead, 8'h00, NoKeys, 1'b1, 1'b1));
    for (int m = ModeSpareLo; m <= ModeSpareHi; m++)
      present(make_event(3'(m), 8'hFF, AllKeys, 1'b1, 1'b1));
    present(make_event(ModeTick,    8'hFF, AllKeys, 1'b1, 1'b1));
    present(make_event(ModeDigit,   8'h00, AllKeys, 1'b0, 1'b0));

    // Blanking off while ages count up, then lower the timeout below them
    // so they miss it, run up to 255 and wrap to idle with digits still lit
    write_timeout(8'd0);
    present(make_event(ModeSegment, 8'hC3, NoKeys, 1'b0, 1'b0));
    present(make_event(ModeDigit,   8'h15, NoKeys, 1'b0, 1'b0));
    tick_run(2);
    present(make_event(ModeDigit,   8'h00, NoKeys, 1'b0, 1'b0));
    tick_run(70);
    write_timeout(8'd30);
    tick_run(200);

    // Random traffic under several timeouts; the last phase runs without idling
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       timeout_value = 8'd1;
        1:       timeout_value = 8'd255;
        4:       timeout_value = TimeoutReset;
        default: timeout_value = 8'($urandom_range(2, 16));
      endcase
      write_timeout(timeout_value);
      if (phase == 4) idling = 1'b0;
      repeat (40) present(random_event());
    end

    drain_and_settle();
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/kpled_pkg.sv
rtl/kpled_key_scan.sv
rtl/keypad_scan_and_led_refresh_core.sv
tb/sv/testbench.sv
